@@ src/integer_to_ascii_formatter_assert.svh @@
// assertion macros used by the formatter back end
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define ITOA_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
        else $error("itoa check failed");

// next-cycle implication, quiet during reset
`define ITOA_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
        else $error("itoa check failed");

`endif

@@ src/itoa_pkg.sv @@
// shared types, codes and helpers for the integer to ascii formatter
package itoa_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int NUM_DIGITS     = 10;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [1:0] OP_DEC  = 2'd0;
    localparam logic [1:0] OP_HEX  = 2'd1;
    localparam logic [1:0] OP_BYTE = 2'd2;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_A_MINUS = 8'h57;

    typedef enum logic [1:0] {
        FMT_DEC,
        FMT_HEX,
        FMT_BYTE
    } t_fmt;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIND,
        ST_EMIT
    } t_state;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ext;
        ext = {4'b0000, nib};
        if (nib < 4'd10) begin
            return ext + CHAR_ZERO;
        end
        return ext + CHAR_A_MINUS;
    endfunction

endpackage

@@ src/integer_to_ascii_formatter.sv @@
// top level of the integer to ascii formatter
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------
//  input   | in        | i_valid / o_ready  | i_value, i_operation
//  output  | out       | o_valid / i_ready  | o_character, o_last
//
// decimal: fetch the job, run the bcd shift-add-3 steps, scan for the top digit, then emit characters
// decimal output at 32 bits is at most ten digits
// hex and hex byte skip the bcd steps: fetch, scan, then emit characters
// the bcd shifter and the single character register pace the conversion and the output
// a two-entry queue lets input transactions land while the back end converts or stalls
// synchronous active-low reset clears the queue, the sequencer and the output valid
module integer_to_ascii_formatter #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value,
    input  logic [1:0]  i_operation,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_character,
    output logic        o_last
);

    localparam int JOB_W = VALUE_BITS + 2;

    logic             push;
    logic [JOB_W-1:0] job_in;
    logic             queue_full;
    logic             pop;
    logic             job_valid;
    logic [JOB_W-1:0] job_out;

    itoa_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .i_operation  (i_operation),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (job_in)
    );

    itoa_queue #(
        .WIDTH (JOB_W),
        .DEPTH (itoa_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_data  (job_out)
    );

    itoa_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_job_pop   (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

@@ src/itoa_queue.sv @@
// small fifo between the classify front and the conversion back
module itoa_queue #(
    parameter int WIDTH = 34,
    parameter int DEPTH = itoa_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ src/itoa_front.sv @@
// input side: accepts transactions, decodes the format and drops the unused selector
module itoa_front #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [31:0]             i_value,
    input  logic [1:0]              i_operation,
    input  logic                    i_queue_full,
    output logic                    o_push,
    output logic [VALUE_BITS+1:0]   o_job
);

    itoa_pkg::t_fmt fmt;
    logic           known;

    always_comb begin
        fmt   = itoa_pkg::FMT_DEC;
        known = 1'b1;
        unique case (i_operation)
            itoa_pkg::OP_DEC:  fmt = itoa_pkg::FMT_DEC;
            itoa_pkg::OP_HEX:  fmt = itoa_pkg::FMT_HEX;
            itoa_pkg::OP_BYTE: fmt = itoa_pkg::FMT_BYTE;
            default:           known = 1'b0;
        endcase
    end

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full && known;
    assign o_job   = {fmt, i_value[VALUE_BITS-1:0]};

endmodule

@@ src/itoa_back.sv @@
// conversion side: binary to bcd by shift-add-3, digit scan and character output register
module itoa_back #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  logic [VALUE_BITS+1:0] i_job,
    output logic                  o_job_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_character,
    output logic                  o_last
);

    `include "integer_to_ascii_formatter_assert.svh"

    localparam int STEPS    = (VALUE_BITS + 3) / 4;
    localparam int PAD_BITS = STEPS * 4;
    localparam int DIG_BITS = itoa_pkg::NUM_DIGITS * 4;
    localparam int IDX_W    = $clog2(itoa_pkg::NUM_DIGITS);
    localparam int CNT_W    = (STEPS > 1) ? $clog2(STEPS) : 1;

    itoa_pkg::t_state r_state, n_state;
    itoa_pkg::t_fmt   r_fmt;
    itoa_pkg::t_fmt   job_fmt;
    logic [PAD_BITS-1:0] job_value;
    logic [PAD_BITS-1:0] r_bin;
    logic [DIG_BITS-1:0] r_digits;
    logic [DIG_BITS-1:0] dabble;
    logic [CNT_W-1:0]    r_cnt;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    top_idx;
    logic [3:0]          cur_digit;
    logic                out_free;
    logic                emit_fire;
    logic                conv_done;
    logic                r_out_valid;
    logic [7:0]          r_out_char;
    logic                r_out_last;

    assign job_fmt   = itoa_pkg::t_fmt'(i_job[VALUE_BITS+1:VALUE_BITS]);
    assign job_value = PAD_BITS'(i_job[VALUE_BITS-1:0]);
    assign out_free  = !r_out_valid || i_ready;
    assign cur_digit = r_digits[{r_idx, 2'b00} +: 4];

    // four bits of shift-add-3 per cycle
    always_comb begin
        dabble = r_digits;
        for (int s = 0; s < 4; s++) begin
            for (int d = 0; d < itoa_pkg::NUM_DIGITS; d++) begin
                if (dabble[d*4 +: 4] >= 4'd5) begin
                    dabble[d*4 +: 4] = dabble[d*4 +: 4] + 4'd3;
                end
            end
            dabble = {dabble[DIG_BITS-2:0], r_bin[PAD_BITS-1-s]};
        end
    end

    // highest nonzero digit, zero when all digits are zero
    always_comb begin
        top_idx = '0;
        for (int d = 0; d < itoa_pkg::NUM_DIGITS; d++) begin
            if (r_digits[d*4 +: 4] != 4'd0) begin
                top_idx = IDX_W'(d);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itoa_pkg::ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = (job_fmt == itoa_pkg::FMT_DEC) ? itoa_pkg::ST_CONV
                                                            : itoa_pkg::ST_FIND;
                end
            end
            itoa_pkg::ST_CONV: begin
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    n_state = itoa_pkg::ST_FIND;
                end
            end
            itoa_pkg::ST_FIND: n_state = itoa_pkg::ST_EMIT;
            itoa_pkg::ST_EMIT: begin
                if (out_free && r_idx == '0) begin
                    n_state = itoa_pkg::ST_IDLE;
                end
            end
            default: n_state = itoa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop = 1'b0;
        emit_fire = 1'b0;
        conv_done = 1'b0;
        unique case (r_state)
            itoa_pkg::ST_IDLE: o_job_pop = i_job_valid;
            itoa_pkg::ST_CONV: conv_done = (r_cnt == CNT_W'(STEPS - 1));
            itoa_pkg::ST_FIND: ;
            itoa_pkg::ST_EMIT: emit_fire = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itoa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            itoa_pkg::ST_IDLE: begin
                r_fmt <= job_fmt;
                r_bin <= job_value;
                r_cnt <= '0;
                if (job_fmt == itoa_pkg::FMT_DEC) begin
                    r_digits <= '0;
                end else begin
                    r_digits <= DIG_BITS'(job_value);
                end
            end
            itoa_pkg::ST_CONV: begin
                r_digits <= dabble;
                r_bin    <= r_bin << 4;
                if (!conv_done) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            itoa_pkg::ST_FIND: begin
                r_idx <= (r_fmt == itoa_pkg::FMT_BYTE) ? IDX_W'(1) : top_idx;
            end
            itoa_pkg::ST_EMIT: begin
                if (emit_fire && r_idx != '0) begin
                    r_idx <= r_idx - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out_char <= itoa_pkg::hex_char(cur_digit);
            r_out_last <= (r_idx == '0);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_out_char;
    assign o_last      = r_out_last;

    `ITOA_ASSERT_NEXT(a_last_on_final, i_clk, i_rst_n, emit_fire && r_idx == '0, r_out_last)
    `ITOA_ASSERT_NEXT(a_more_follow, i_clk, i_rst_n, emit_fire && r_idx != '0, !r_out_last)
    `ITOA_ASSERT_IMPLIES(a_no_pop_busy, i_clk, i_rst_n, o_job_pop, r_state == itoa_pkg::ST_IDLE)
    `ITOA_ASSERT_IMPLIES(a_ascii_digit, i_clk, i_rst_n, r_out_valid,
        (r_out_char >= 8'h30 && r_out_char <= 8'h39) ||
        (r_out_char >= 8'h61 && r_out_char <= 8'h66))

endmodule
